// ===== rtl/core/iso_timestamp_to_epoch_parser_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the timestamp parser checker
// ----------------------------------------------------------------------------
`ifndef ISO_TIMESTAMP_TO_EPOCH_PARSER_UNIT_DEFINES_SVH
`define ISO_TIMESTAMP_TO_EPOCH_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ISTP_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled during reset
`define ISTP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/core/istp_pkg.sv =====
// ----------------------------------------------------------------------------
// istp_pkg
// Types, character codes and calendar tables for the timestamp parser.
// ----------------------------------------------------------------------------
package istp_pkg;

    localparam logic [4:0]  TEXT_LEN     = 5'd20;
    localparam logic [7:0]  CH_ZERO      = 8'h30;
    localparam logic [7:0]  CH_NINE      = 8'h39;
    localparam logic [7:0]  CH_DASH      = 8'h2D;
    localparam logic [7:0]  CH_COLON     = 8'h3A;
    localparam logic [7:0]  CH_T         = 8'h54;
    localparam logic [7:0]  CH_Z         = 8'h5A;
    localparam logic [7:0]  CH_NONE      = 8'h00;
    localparam logic [31:0] DAYS_PER_ERA = 32'd146097;
    localparam logic [31:0] EPOCH_SHIFT  = 32'd719468;
    localparam logic [31:0] SEC_PER_DAY  = 32'd86400;

    // one parsed timestamp handed from front to back
    typedef struct packed {
        logic       ok_pre;   // format and length good
        logic [6:0] yr_hi;    // first two year digits
        logic [6:0] yr_lo;    // last two year digits
        logic [6:0] month;
        logic [6:0] day;
        logic [6:0] hour;
        logic [6:0] minute;
        logic [6:0] second;
    } istp_rec_t;

    // required separator at a position, CH_NONE where a digit goes
    function automatic logic [7:0] sep_for_pos(input logic [4:0] pos);
        logic [7:0] s;
        unique case (pos)
            5'd4, 5'd7:   s = CH_DASH;
            5'd10:        s = CH_T;
            5'd13, 5'd16: s = CH_COLON;
            5'd19:        s = CH_Z;
            default:      s = CH_NONE;
        endcase
        return s;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m);
        logic [4:0] d;
        unique case (m)
            4'd2:                      d = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

    // day of year at month start, March-based month index
    function automatic logic [8:0] doy_start(input logic [3:0] mm);
        logic [8:0] d;
        unique case (mm)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/core/iso_timestamp_to_epoch_parser_unit.sv =====
// ----------------------------------------------------------------------------
// iso_timestamp_to_epoch_parser_unit
// Parses YYYY-MM-DDThh:mm:ssZ text into Unix seconds.
// ----------------------------------------------------------------------------
// Characters are taken one per cycle while the timestamp queue has room.
// A result passes from the queue through the back end states CHK, ERA, YOE,
// DOE, DAYS, MUL and OUT; the back end works on one timestamp at a time.
// The queue (QUEUE_DEPTH entries) lets the next text stream in meanwhile.
// Synchronous active-low reset clears the parser position, queue and output.
module iso_timestamp_to_epoch_parser_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] epoch_seconds
    output logic [0:0]  m_tuser    // [0] ok
);

    logic                q_full, q_empty, push, pop;
    istp_pkg::istp_rec_t push_rec, head_rec;

    assign s_tready = !q_full;

    istp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (s_tvalid && s_tready),
        .char_code   (s_tdata),
        .end_of_text (s_tlast),
        .push        (push),
        .rec         (push_rec)
    );

    istp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .empty    (q_empty),
        .full     (q_full)
    );

    istp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_rec  (head_rec),
        .empty     (q_empty),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_ok    (m_tuser[0]),
        .out_secs  (m_tdata)
    );

endmodule

// ===== rtl/core/istp_front.sv =====
// ----------------------------------------------------------------------------
// istp_front
// Checks each character against its position and accumulates the fields.
// ----------------------------------------------------------------------------
module istp_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic [7:0]           char_code,
    input  logic                 end_of_text,
    output logic                 push,
    output istp_pkg::istp_rec_t  rec
);

    logic [4:0] pos_reg, pos_next;
    logic       err_reg, err_next;
    logic [6:0] yhi_reg, yhi_next, ylo_reg, ylo_next;
    logic [6:0] mon_reg, mon_next, day_reg, day_next;
    logic [6:0] hr_reg, hr_next, min_reg, min_next, sec_reg, sec_next;

    logic       is_digit;
    logic [3:0] dv;
    logic [7:0] sep;

    function automatic logic [6:0] acc(input logic [6:0] v, input logic [3:0] d);
        logic [10:0] t;
        t = 11'(v) * 11'd10 + 11'(d);
        return t[6:0];
    endfunction

    assign is_digit = (char_code >= istp_pkg::CH_ZERO) && (char_code <= istp_pkg::CH_NINE);
    assign dv       = char_code[3:0];
    assign sep      = istp_pkg::sep_for_pos(pos_reg);

    always_comb begin
        pos_next = pos_reg;
        err_next = err_reg;
        yhi_next = yhi_reg;
        ylo_next = ylo_reg;
        mon_next = mon_reg;
        day_next = day_reg;
        hr_next  = hr_reg;
        min_next = min_reg;
        sec_next = sec_reg;
        if ((char_code == 8'd0) || (pos_reg >= istp_pkg::TEXT_LEN)) begin
            err_next = 1'b1;
        end else begin
            pos_next = pos_reg + 5'd1;
            if (sep != istp_pkg::CH_NONE) begin
                if (char_code != sep) err_next = 1'b1;
            end else if (!is_digit) begin
                err_next = 1'b1;
            end else begin
                priority if (pos_reg < 5'd2) begin
                    yhi_next = acc(yhi_reg, dv);
                end else if (pos_reg < 5'd4) begin
                    ylo_next = acc(ylo_reg, dv);
                end else if (pos_reg < 5'd7) begin
                    mon_next = acc(mon_reg, dv);
                end else if (pos_reg < 5'd10) begin
                    day_next = acc(day_reg, dv);
                end else if (pos_reg < 5'd13) begin
                    hr_next = acc(hr_reg, dv);
                end else if (pos_reg < 5'd16) begin
                    min_next = acc(min_reg, dv);
                end else begin
                    sec_next = acc(sec_reg, dv);
                end
            end
        end
    end

    assign push = accept && end_of_text;

    always_comb begin
        rec.ok_pre = !err_next && (pos_next == istp_pkg::TEXT_LEN);
        rec.yr_hi  = yhi_next;
        rec.yr_lo  = ylo_next;
        rec.month  = mon_next;
        rec.day    = day_next;
        rec.hour   = hr_next;
        rec.minute = min_next;
        rec.second = sec_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || push) begin
            pos_reg <= '0;
            err_reg <= 1'b0;
            yhi_reg <= '0;
            ylo_reg <= '0;
            mon_reg <= '0;
            day_reg <= '0;
            hr_reg  <= '0;
            min_reg <= '0;
            sec_reg <= '0;
        end else if (accept) begin
            pos_reg <= pos_next;
            err_reg <= err_next;
            yhi_reg <= yhi_next;
            ylo_reg <= ylo_next;
            mon_reg <= mon_next;
            day_reg <= day_next;
            hr_reg  <= hr_next;
            min_reg <= min_next;
            sec_reg <= sec_next;
        end
    end

endmodule

// ===== rtl/core/istp_queue.sv =====
// ----------------------------------------------------------------------------
// istp_queue
// Small register queue of parsed timestamps between front and back.
// ----------------------------------------------------------------------------
module istp_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  istp_pkg::istp_rec_t  push_rec,
    input  logic                 pop,
    output istp_pkg::istp_rec_t  head_rec,
    output logic                 empty,
    output logic                 full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    istp_pkg::istp_rec_t mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    cnt_reg;

    assign empty    = (cnt_reg == '0);
    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign head_rec = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/istp_back.sv =====
// ----------------------------------------------------------------------------
// istp_back
// Range checks and civil-days to Unix seconds, one step per cycle while the output is free.
// ----------------------------------------------------------------------------
module istp_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  istp_pkg::istp_rec_t  head_rec,
    input  logic                 empty,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_ok,
    output logic [31:0]          out_secs
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_ERA  = 3'd2;
    localparam logic [2:0] S_YOE  = 3'd3;
    localparam logic [2:0] S_DOE  = 3'd4;
    localparam logic [2:0] S_DAYS = 3'd5;
    localparam logic [2:0] S_MUL  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]          state_reg, state_next;
    istp_pkg::istp_rec_t rec_reg;
    logic                valid_reg;
    logic [3:0]          mm_reg;
    logic [14:0]         x_reg;      // shifted year: y + 400
    logic [4:0]          era_reg;    // era + 1
    logic [8:0]          yoe_reg, doy_reg;
    logic [17:0]         doe_reg;
    logic [16:0]         tod_reg;
    logic [31:0]         days_reg, prod_reg;
    logic                out_valid_reg, out_ok_reg;
    logic [31:0]         out_secs_reg;

    logic [13:0] year;
    logic        leap;
    logic [4:0]  maxd;
    logic        range_ok;
    logic [16:0] era_prod;
    logic [1:0]  c100;
    logic        out_free;

    assign year = 14'(14'(rec_reg.yr_hi) * 14'd100) + 14'(rec_reg.yr_lo);
    // 100 is a multiple of 4, so the low two digits decide; a full century
    // falls back on the high two digits
    assign leap = (rec_reg.yr_lo != 7'd0) ? (rec_reg.yr_lo[1:0] == 2'b00)
                                          : (rec_reg.yr_hi[1:0] == 2'b00);

    always_comb begin
        maxd = istp_pkg::month_days(rec_reg.month[3:0]);
        if ((rec_reg.month == 7'd2) && leap) maxd = 5'd29;
    end

    assign range_ok = (rec_reg.month >= 7'd1) && (rec_reg.month <= 7'd12) &&
                      (rec_reg.day >= 7'd1) && (rec_reg.day <= 7'(maxd)) &&
                      (rec_reg.hour <= 7'd23) && (rec_reg.minute <= 7'd59) &&
                      (rec_reg.second <= 7'd59);

    // floor(x / 400) as floor((x >> 4) * 41 / 1024), exact for x below 16384
    assign era_prod = 17'(x_reg[14:4]) * 17'd41;

    always_comb begin
        priority if (yoe_reg >= 9'd300) c100 = 2'd3;
        else if (yoe_reg >= 9'd200)     c100 = 2'd2;
        else if (yoe_reg >= 9'd100)     c100 = 2'd1;
        else                            c100 = 2'd0;
    end

    assign out_free = !out_valid_reg || out_ready;
    assign pop      = (state_reg == S_IDLE) && !empty;

    always_comb begin
        unique case (state_reg)
            S_IDLE:  state_next = empty ? S_IDLE : S_CHK;
            S_CHK:   state_next = S_ERA;
            S_ERA:   state_next = S_YOE;
            S_YOE:   state_next = S_DOE;
            S_DOE:   state_next = S_DAYS;
            S_DAYS:  state_next = S_MUL;
            S_MUL:   state_next = S_OUT;
            S_OUT:   state_next = out_free ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == S_OUT) && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (!empty) rec_reg <= head_rec;
            end
            S_CHK: begin
                valid_reg <= rec_reg.ok_pre && range_ok;
                mm_reg    <= (rec_reg.month > 7'd2) ? rec_reg.month[3:0] - 4'd3
                                                    : rec_reg.month[3:0] + 4'd9;
                x_reg     <= 15'(year) + 15'd400 - ((rec_reg.month <= 7'd2) ? 15'd1 : 15'd0);
            end
            S_ERA: begin
                era_reg <= era_prod[14:10];
            end
            S_YOE: begin
                yoe_reg <= 9'(x_reg - 15'(era_reg) * 15'd400);
                doy_reg <= istp_pkg::doy_start(mm_reg) + 9'(rec_reg.day) - 9'd1;
                tod_reg <= 17'(rec_reg.hour) * 17'd3600 + 17'(rec_reg.minute) * 17'd60
                         + 17'(rec_reg.second);
            end
            S_DOE: begin
                doe_reg <= 18'(yoe_reg) * 18'd365 + 18'(yoe_reg[8:2]) - 18'(c100)
                         + 18'(doy_reg);
            end
            S_DAYS: begin
                // era_reg holds era + 1
                days_reg <= 32'(era_reg) * istp_pkg::DAYS_PER_ERA + 32'(doe_reg)
                          - istp_pkg::DAYS_PER_ERA - istp_pkg::EPOCH_SHIFT;
            end
            S_MUL: begin
                prod_reg <= days_reg * istp_pkg::SEC_PER_DAY;
            end
            S_OUT: begin
                if (out_free) begin
                    out_ok_reg   <= valid_reg;
                    out_secs_reg <= valid_reg ? prod_reg + 32'(tod_reg) : 32'd0;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_ok    = out_ok_reg;
    assign out_secs  = out_secs_reg;

endmodule

// ===== rtl/core/istp_checker.sv =====
// ----------------------------------------------------------------------------
// istp_checker
// Port-level checks on the result channel of the timestamp parser.
// ----------------------------------------------------------------------------
`include "iso_timestamp_to_epoch_parser_unit_defines.svh"

module istp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser
);

    `ISTP_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    // a rejected timestamp carries zero seconds
    `ISTP_ASSERT_IMPL(a_bad_is_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata == 32'd0)
    // a waiting result keeps its fields
    `ISTP_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))

endmodule

bind iso_timestamp_to_epoch_parser_unit istp_checker u_istp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== sim/iso_timestamp_to_epoch_parser_unit_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timestamp parser checker
// Watches both stream channels of the timestamp parser. Each accepted
// character is parsed here as well, every flagged character queues a
// predicted result, and each result taken from the block is compared field by
// field with the oldest prediction. Mismatches are counted for the testbench.
// ----------------------------------------------------------------------------
module iso_timestamp_to_epoch_parser_unit_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [0:0]  m_tuser,
    output int          fail_count,
    output int          stamps_pending,
    output int          results_seen,
    output int          good_results
);

    localparam logic [31:0] SEC_PER_HOUR = 32'd3600;
    localparam logic [31:0] SEC_PER_MIN  = 32'd60;
    localparam logic [7:0]  DIGIT_SLOT   = "d";
    // character class per position, position 0 in the top byte
    localparam logic [8*20-1:0] TEXT_LAYOUT = "dddd-dd-ddTdd:dd:ddZ";

    typedef struct packed {
        logic        ok;
        logic [31:0] seconds;
    } stamp_t;

    stamp_t predicted_stamps[$];

    logic [4:0]  text_pos;
    logic [13:0] acc_year;
    logic [6:0]  acc_month;
    logic [6:0]  acc_day;
    logic [6:0]  acc_hour;
    logic [6:0]  acc_minute;
    logic [6:0]  acc_second;
    logic        bad_format;

    function automatic void clear_fields();
        text_pos   = '0;
        acc_year   = '0;
        acc_month  = '0;
        acc_day    = '0;
        acc_hour   = '0;
        acc_minute = '0;
        acc_second = '0;
        bad_format = 1'b0;
    endfunction

    function automatic logic is_leap(input logic [13:0] y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int month_length(input logic [6:0] m, input logic [13:0] y);
        case (m)
            7'd2:                    return is_leap(y) ? 29 : 28;
            7'd4, 7'd6, 7'd9, 7'd11: return 30;
            default:                 return 31;
        endcase
    endfunction

    function automatic logic date_in_range();
        if (acc_month < 1 || acc_month > 12 || acc_day < 1)
            return 1'b0;
        if (acc_hour > 23 || acc_minute > 59 || acc_second > 59)
            return 1'b0;
        return acc_day <= month_length(acc_month, acc_year);
    endfunction

    // seconds from 1970-01-01 by the March-based era method, wrapped to 32 bits
    function automatic logic [31:0] epoch_of_fields();
        longint yy, era, yoe, mp, doy, doe, days;
        yy   = longint'(acc_year) - (acc_month <= 2 ? 1 : 0);
        era  = (yy >= 0 ? yy : yy - 399) / 400;
        yoe  = yy - era * 400;
        mp   = longint'(acc_month) + (acc_month > 2 ? -3 : 9);
        doy  = (153 * mp + 2) / 5 + longint'(acc_day) - 1;
        doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        days = era * longint'(istp_pkg::DAYS_PER_ERA) + doe
             - longint'(istp_pkg::EPOCH_SHIFT);
        return 32'(days) * istp_pkg::SEC_PER_DAY + 32'(acc_hour) * SEC_PER_HOUR
             + 32'(acc_minute) * SEC_PER_MIN + 32'(acc_second);
    endfunction

    function automatic void parse_char(input logic [7:0] c, input logic last);
        logic [7:0] slot;
        logic [3:0] digit;
        logic       is_digit;
        stamp_t     res;
        is_digit = (c >= istp_pkg::CH_ZERO) && (c <= istp_pkg::CH_NINE);
        digit    = 4'(c - istp_pkg::CH_ZERO);
        if (c == istp_pkg::CH_NONE || text_pos >= istp_pkg::TEXT_LEN) begin
            // zero byte or overlong text: position stays put
            bad_format = 1'b1;
        end else begin
            slot = TEXT_LAYOUT[8 * (19 - text_pos) +: 8];
            if (slot != DIGIT_SLOT) begin
                if (c != slot)
                    bad_format = 1'b1;
            end else if (!is_digit) begin
                bad_format = 1'b1;
            end else if (text_pos < 4) begin
                acc_year = 14'(acc_year * 10 + digit);
            end else if (text_pos < 7) begin
                acc_month = 7'(acc_month * 10 + digit);
            end else if (text_pos < 10) begin
                acc_day = 7'(acc_day * 10 + digit);
            end else if (text_pos < 13) begin
                acc_hour = 7'(acc_hour * 10 + digit);
            end else if (text_pos < 16) begin
                acc_minute = 7'(acc_minute * 10 + digit);
            end else begin
                acc_second = 7'(acc_second * 10 + digit);
            end
            text_pos = text_pos + 5'd1;
        end
        if (last) begin
            res.ok      = !bad_format && text_pos == istp_pkg::TEXT_LEN && date_in_range();
            res.seconds = res.ok ? epoch_of_fields() : '0;
            predicted_stamps.push_back(res);
            clear_fields();
        end
    endfunction

    always @(posedge aclk) begin
        stamp_t got;
        stamp_t want;
        int     errs;
        errs = 0;
        if (!aresetn) begin
            clear_fields();
            predicted_stamps.delete();
            fail_count   <= 0;
            results_seen <= 0;
            good_results <= 0;
        end else begin
            // take the input first so a same-edge result would still find its entry
            if (s_tvalid && s_tready)
                parse_char(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                got.ok      = m_tuser[0];
                got.seconds = m_tdata;
                results_seen <= results_seen + 1;
                if (got.ok === 1'b1)
                    good_results <= good_results + 1;
                if (predicted_stamps.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got ok=%0b seconds=%0d",
                             $time, got.ok, got.seconds);
                    errs++;
                end else begin
                    want = predicted_stamps.pop_front();
                    if (got.ok !== want.ok) begin
                        $display("%0t: ok mismatch, expected %0b, got %0b",
                                 $time, want.ok, got.ok);
                        errs++;
                    end
                    if (got.seconds !== want.seconds) begin
                        $display("%0t: epoch mismatch, expected %0d, got %0d",
                                 $time, want.seconds, got.seconds);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
        stamps_pending <= predicted_stamps.size();
    end

endmodule

// ===== sim/iso_timestamp_to_epoch_parser_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timestamp parser testbench
// Streams timestamp texts into the parser one character per item: a directed
// set of calendar edges and malformed texts, then random well-formed,
// damaged and noise texts under three idle patterns on both channels. The
// checker instance predicts and compares every result.
// ----------------------------------------------------------------------------
module iso_timestamp_to_epoch_parser_unit_tb;

    localparam int CYCLE_LIMIT       = 200000;
    localparam int RANDOM_CHARS      = 500;
    localparam int LONG_STALL_CYCLES = 400;
    localparam int DRAIN_CYCLES      = 24;

    localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;
    localparam logic [7:0] BYTE_HIGH_BIT = 8'h80;
    localparam int EDGE_YEARS[14] = '{0, 1, 4, 100, 400, 1900, 1969, 1970, 2000, 2038,
                                      2100, 2106, 2107, 9999};

    typedef enum {DAMAGE_BYTE, DAMAGE_SHORT, DAMAGE_LONG} damage_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;

    int fail_count;
    int stamps_pending;
    int results_seen;
    int good_results;

    int send_idle_pct = 27;
    int recv_idle_pct = 62;
    int stalls_asked  = 0;
    int stalls_done   = 0;
    int chars_sent    = 0;
    int texts_sent    = 0;
    int cycle_count   = 0;

    logic [7:0] text_q[$];

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    iso_timestamp_to_epoch_parser_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    iso_timestamp_to_epoch_parser_unit_checker u_chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .fail_count     (fail_count),
        .stamps_pending (stamps_pending),
        .results_seen   (results_seen),
        .good_results   (good_results)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, stamps_pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: random backpressure, or a long hold-off when one is asked
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stalls_done != stalls_asked) begin
                m_tready <= 1'b0;
                repeat (LONG_STALL_CYCLES) @(posedge aclk);
                stalls_done++;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        chars_sent++;
    endtask

    task automatic send_text();
        foreach (text_q[i])
            send_char(text_q[i], i == text_q.size() - 1);
        texts_sent++;
    endtask

    function automatic void put_num(input int v, input int digits);
        int scale;
        scale = 1;
        repeat (digits - 1) scale *= 10;
        for (int k = 0; k < digits; k++) begin
            text_q.push_back(8'(istp_pkg::CH_ZERO + (v / scale) % 10));
            scale /= 10;
        end
    endfunction

    function automatic void build_stamp(input int y, input int mo, input int d,
                                        input int h, input int mi, input int sec);
        text_q.delete();
        put_num(y, 4);
        text_q.push_back(istp_pkg::CH_DASH);
        put_num(mo, 2);
        text_q.push_back(istp_pkg::CH_DASH);
        put_num(d, 2);
        text_q.push_back(istp_pkg::CH_T);
        put_num(h, 2);
        text_q.push_back(istp_pkg::CH_COLON);
        put_num(mi, 2);
        text_q.push_back(istp_pkg::CH_COLON);
        put_num(sec, 2);
        text_q.push_back(istp_pkg::CH_Z);
    endfunction

    task automatic send_stamp(input int y, input int mo, input int d,
                              input int h, input int mi, input int sec);
        build_stamp(y, mo, d, h, mi, sec);
        send_text();
    endtask

    task automatic wait_for_drain();
        @(posedge aclk);
        while (stamps_pending != 0) @(posedge aclk);
    endtask

    task automatic run_directed();
        send_stamp(1970, 1, 1, 0, 0, 0);
        send_stamp(2038, 1, 19, 3, 14, 7);
        send_stamp(2106, 2, 7, 6, 28, 15);      // last second before wrap
        send_stamp(2106, 2, 7, 6, 28, 16);      // wraps to zero
        send_stamp(1969, 12, 31, 23, 59, 59);   // negative day count
        send_stamp(0, 1, 1, 0, 0, 0);
        send_stamp(9999, 12, 31, 23, 59, 59);
        send_stamp(0, 2, 29, 12, 0, 0);         // year zero is leap
        send_stamp(2000, 2, 29, 1, 2, 3);
        send_stamp(1900, 2, 29, 1, 2, 3);
        send_stamp(2023, 2, 29, 1, 2, 3);
        send_stamp(2021, 4, 31, 0, 0, 0);
        send_stamp(2021, 0, 10, 0, 0, 0);
        send_stamp(2021, 13, 10, 0, 0, 0);
        send_stamp(2021, 5, 0, 0, 0, 0);
        send_stamp(1999, 12, 31, 24, 0, 0);
        send_stamp(1999, 12, 31, 23, 60, 0);
        send_stamp(1999, 12, 31, 23, 59, 60);
        build_stamp(2020, 6, 15, 12, 30, 45);
        text_q[5] = istp_pkg::CH_NONE;
        send_text();
        build_stamp(2020, 6, 15, 12, 30, 45);
        text_q[0] = BYTE_ALL_ONES;
        text_q[4] = BYTE_HIGH_BIT;
        send_text();
        build_stamp(2020, 6, 15, 12, 30, 45);
        text_q[10] = istp_pkg::CH_COLON;        // wrong separator
        send_text();
        build_stamp(2020, 6, 15, 12, 30, 45);
        while (text_q.size() > 10) void'(text_q.pop_back());
        send_text();
        build_stamp(2020, 6, 15, 12, 30, 45);
        text_q.push_back(istp_pkg::CH_ZERO);
        text_q.push_back(istp_pkg::CH_Z);
        send_text();
        text_q.delete();
        text_q.push_back(istp_pkg::CH_NONE);
        send_text();
    endtask

    task automatic send_random_text();
        int      roll, y, mo, d, h, mi, sec, cut;
        damage_t damage;
        roll = $urandom_range(99);
        if (roll < 10) begin
            text_q.delete();
            repeat ($urandom_range(25, 1)) text_q.push_back(8'($urandom_range(255)));
        end else begin
            case ($urandom_range(3))
                0:       y = $urandom_range(9999);
                1:       y = $urandom_range(2106, 1970);
                2:       y = $urandom_range(2040, 1995);
                default: y = EDGE_YEARS[$urandom_range(13)];
            endcase
            mo  = ($urandom_range(99) < 88) ? $urandom_range(12, 1) : $urandom_range(99);
            d   = ($urandom_range(99) < 88) ? $urandom_range(31, 1) : $urandom_range(99);
            if ($urandom_range(9) == 0)
                d = $urandom_range(31, 28);     // month ends
            h   = ($urandom_range(99) < 90) ? $urandom_range(23) : $urandom_range(99);
            mi  = ($urandom_range(99) < 90) ? $urandom_range(59) : $urandom_range(99);
            sec = ($urandom_range(99) < 90) ? $urandom_range(59) : $urandom_range(99);
            build_stamp(y, mo, d, h, mi, sec);
            if (roll < 25) begin
                damage = damage_t'($urandom_range(2));
                case (damage)
                    DAMAGE_BYTE: text_q[$urandom_range(19)] = 8'($urandom_range(255));
                    DAMAGE_SHORT: begin
                        cut = $urandom_range(19, 1);
                        while (text_q.size() > cut) void'(text_q.pop_back());
                    end
                    DAMAGE_LONG: begin
                        repeat ($urandom_range(5, 1))
                            text_q.push_back(8'($urandom_range(255)));
                    end
                endcase
            end
        end
        send_text();
    endtask

    initial begin
        int directed_chars;
        int random_done;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= istp_pkg::CH_NONE;
        s_tlast  <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        s_tvalid <= 1'b0;
        wait_for_drain();

        // output held off while texts keep coming, so the queue fills
        directed_chars = chars_sent;
        stalls_asked++;
        random_done = 0;
        while (random_done < RANDOM_CHARS) begin
            if (random_done >= 2 * RANDOM_CHARS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (random_done >= RANDOM_CHARS / 3) begin
                send_idle_pct = 62;
                recv_idle_pct = 27;
            end
            send_random_text();
            random_done = chars_sent - directed_chars;
        end
        s_tvalid <= 1'b0;
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d characters in %0d texts; %0d results compared, %0d valid.",
                 chars_sent, texts_sent, results_seen, good_results);
        $display("Covered calendar edges, malformed texts, a %0d-cycle output stall",
                 LONG_STALL_CYCLES);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/istp_pkg.sv
rtl/core/istp_front.sv
rtl/core/istp_queue.sv
rtl/core/istp_back.sv
rtl/core/iso_timestamp_to_epoch_parser_unit.sv
rtl/core/istp_checker.sv
sim/iso_timestamp_to_epoch_parser_unit_checker.sv
sim/iso_timestamp_to_epoch_parser_unit_tb.sv
